[sv/tess_pkg.sv]
package tess_pkg;

  // coordinate format
  localparam int COORD_FRAC_BITS = 8;
  localparam int COORD_INT_BITS  = 16;

  // field and internal widths
  localparam int VTX_W      = 24;
  localparam int IN_DATA_W  = 6 * VTX_W;
  localparam int OUT_W      = COORD_INT_BITS;
  localparam int OUT_DATA_W = 3 * OUT_W;
  localparam int ROW_W      = VTX_W - COORD_FRAC_BITS + 1;
  localparam int SUM_W      = VTX_W + 2;
  localparam int OFS_W      = VTX_W + 2;
  localparam int PRD_W      = 2 * OFS_W;
  localparam int AREA_W     = PRD_W + 2;
  localparam int DY_W       = ROW_W + 1;
  localparam int BDY_W      = OFS_W + DY_W;
  localparam int NUM_W      = 48;
  localparam int DEN_W      = OFS_W;
  localparam int RES_W      = NUM_W + 1;
  localparam int CNT_W      = $clog2(NUM_W);

  // result status codes
  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_SPAN   = 2'd1,
    ST_DONE   = 2'd2
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic    capture;
    logic    load_box;
    logic    div_start;
    logic    cent_take;
    logic    offs;
    logic    prod;
    logic    coef;
    logic    flip;
    logic    row_step;
    logic    mult;
    logic    merge;
    logic    out_load;
    status_t out_status;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
    logic past_last;
    logic next_past;
    logic out_full;
  } sts_t;

endpackage

[sv/tess_div.sv]
module tess_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [tess_pkg::NUM_W-1:0]    num,
  input  logic        [tess_pkg::DEN_W-1:0]    den,
  output logic                                 done,
  output logic signed [tess_pkg::NUM_W-1:0]    quo
);
  import tess_pkg::*;

  logic                busy_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                neg_r;
  logic [NUM_W-1:0]    mag_r;
  logic [DEN_W-1:0]    rem_r;
  logic [DEN_W-1:0]    den_r;
  logic [DEN_W:0]      rem_sh;
  logic [DEN_W:0]      rem_sub;
  logic                ge;
  logic [NUM_W-1:0]    mag_adj;

  // one restoring step per cycle
  always_comb begin
    rem_sh  = {rem_r, mag_r[NUM_W-1]};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_sub = rem_sh - {1'b0, den_r};
  end

  // floor correction for negative dividends
  always_comb begin
    mag_adj = mag_r + NUM_W'(rem_r != '0);
    quo     = neg_r ? signed'(-mag_adj) : signed'(mag_r);
  end

  // done once all quotient bits are in
  assign done = busy_r && (cnt_r == CNT_W'(NUM_W));

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (done) begin
        busy_r <= 1'b0;
      end
    end
  end

  // operands
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NUM_W-1];
      mag_r <= num[NUM_W-1] ? unsigned'(-num) : unsigned'(num);
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r && !done) begin
      mag_r <= {mag_r[NUM_W-2:0], ge};
      rem_r <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

endmodule

[sv/tess_dp.sv]
module tess_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tess_pkg::cmd_t                      cmd,
  output tess_pkg::sts_t                      sts,
  input  logic [tess_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tess_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [1:0]                          out_tuser
);
  import tess_pkg::*;

  localparam logic signed [RES_W-1:0] OUT_MIN = RES_W'(-(2 ** (OUT_W - 1)));
  localparam logic signed [RES_W-1:0] OUT_MAX = RES_W'(2 ** (OUT_W - 1) - 1);

  // centroid divide by three: bias to nonnegative, then reciprocal multiply
  localparam int CEN_W    = SUM_W - COORD_FRAC_BITS;
  localparam int THIRD_SH = CEN_W + 1;
  localparam logic [CEN_W-1:0] CEN_BIAS    = CEN_W'(3 * (2 ** (ROW_W - 2)));
  localparam logic [CEN_W-1:0] THIRD_RECIP = CEN_W'((2 ** THIRD_SH + 2) / 3);
  localparam logic [ROW_W-1:0] CEN_OFS     = ROW_W'(2 ** (ROW_W - 2));

  function automatic logic signed [VTX_W-1:0] min3(input logic signed [VTX_W-1:0] a,
                                                   input logic signed [VTX_W-1:0] b,
                                                   input logic signed [VTX_W-1:0] c);
    logic signed [VTX_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [VTX_W-1:0] max3(input logic signed [VTX_W-1:0] a,
                                                   input logic signed [VTX_W-1:0] b,
                                                   input logic signed [VTX_W-1:0] c);
    logic signed [VTX_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic signed [RES_W-1:0] clip(input logic signed [RES_W-1:0] v,
                                                   input logic signed [RES_W-1:0] lo,
                                                   input logic signed [RES_W-1:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // vertices: ax, ay, bx, by, cx, cy
  logic signed [VTX_W-1:0] vtx_r [6];
  logic signed [ROW_W-1:0] box_lo_r, box_hi_r, last_r, cur_r, gx_r, gy_r;
  logic [CEN_W-1:0]        cnx_r, cny_r;
  logic signed [OFS_W-1:0] ofs_r [6];
  logic signed [PRD_W-1:0] prd_r [6];
  logic signed [OFS_W-1:0] ca_r [3];
  logic signed [OFS_W-1:0] cb_r [3];
  logic signed [PRD_W-1:0] cc_r [3];
  logic signed [BDY_W-1:0] bdy_r [3];
  logic signed [RES_W-1:0] start_r, end_r;
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic [1:0]              out_user_r;

  logic signed [VTX_W-1:0] xmin, xmax, ymin, ymax;
  logic signed [VTX_W:0]   xmin_c, ymin_c;
  logic signed [SUM_W-1:0] sx, sy;
  logic [2*CEN_W-1:0]      cpx, cpy;
  logic signed [ROW_W-1:0] first_row;
  logic signed [OFS_W-1:0] gx8, gy8;
  logic signed [AREA_W-1:0] area;
  logic signed [ROW_W:0]   cur_inc;
  logic signed [DY_W-1:0]  dy;
  logic signed [NUM_W-1:0] div_num [3];
  logic [DEN_W-1:0]        div_den [3];
  logic signed [NUM_W-1:0] div_quo [3];
  logic                    div_done [3];
  logic signed [RES_W-1:0] st_c, en_c, cand;
  logic signed [RES_W-1:0] so, eo, row_c;
  logic                    in_rng;

  // bounding box, centroid sums and reciprocal products, area and row arithmetic
  always_comb begin
    xmin   = min3(vtx_r[0], vtx_r[2], vtx_r[4]);
    xmax   = max3(vtx_r[0], vtx_r[2], vtx_r[4]);
    ymin   = min3(vtx_r[1], vtx_r[3], vtx_r[5]);
    ymax   = max3(vtx_r[1], vtx_r[3], vtx_r[5]);
    xmin_c = (VTX_W + 1)'(xmin) + (VTX_W + 1)'((2 ** COORD_FRAC_BITS) - 1);
    ymin_c = (VTX_W + 1)'(ymin) + (VTX_W + 1)'((2 ** COORD_FRAC_BITS) - 1);
    first_row = ROW_W'(ymin_c >>> COORD_FRAC_BITS);
    sx = SUM_W'(vtx_r[0]) + SUM_W'(vtx_r[2]) + SUM_W'(vtx_r[4]);
    sy = SUM_W'(vtx_r[1]) + SUM_W'(vtx_r[3]) + SUM_W'(vtx_r[5]);
    cpx = cnx_r * THIRD_RECIP;
    cpy = cny_r * THIRD_RECIP;
    gx8 = OFS_W'(gx_r) <<< COORD_FRAC_BITS;
    gy8 = OFS_W'(gy_r) <<< COORD_FRAC_BITS;
    area = AREA_W'(cc_r[0]) + AREA_W'(cc_r[1]) + AREA_W'(cc_r[2]);
    cur_inc = (ROW_W + 1)'(cur_r) + (ROW_W + 1)'(1);
    dy = DY_W'(cur_r) - DY_W'(gy_r);
  end

  assign sts.past_last = (cur_r > last_r);
  assign sts.next_past = (cur_inc > (ROW_W + 1)'(last_r));

  // divider operands: span divides by |A|
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div_num[i] = NUM_W'(bdy_r[i]) + NUM_W'(cc_r[i] >>> COORD_FRAC_BITS);
      div_den[i] = ca_r[i][OFS_W-1] ? unsigned'(-ca_r[i]) : unsigned'(ca_r[i]);
    end
  end

  // three division lanes, one per edge
  for (genvar g = 0; g < 3; g++) begin : g_lane
    tess_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (cmd.div_start),
      .num   (div_num[g]),
      .den   (div_den[g]),
      .done  (div_done[g]),
      .quo   (div_quo[g])
    );
  end

  assign sts.div_done = div_done[0];

  // row registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '1;
      cur_r  <= '0;
    end else if (cmd.load_box) begin
      last_r <= ROW_W'(ymax >>> COORD_FRAC_BITS);
      cur_r  <= first_row - ROW_W'(1);
    end else if (cmd.row_step) begin
      cur_r <= cur_inc[ROW_W-1:0];
    end
  end

  // setup pipeline
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < 6; i++) begin
        vtx_r[i] <= in_tdata[i*VTX_W +: VTX_W];
      end
    end
    if (cmd.load_box) begin
      box_lo_r <= ROW_W'(xmin_c >>> COORD_FRAC_BITS);
      box_hi_r <= ROW_W'(xmax >>> COORD_FRAC_BITS);
      cnx_r    <= CEN_W'(sx >>> COORD_FRAC_BITS) + CEN_BIAS;
      cny_r    <= CEN_W'(sy >>> COORD_FRAC_BITS) + CEN_BIAS;
    end
    if (cmd.cent_take) begin
      gx_r <= cpx[2*CEN_W-1:THIRD_SH] - CEN_OFS;
      gy_r <= cpy[2*CEN_W-1:THIRD_SH] - CEN_OFS;
    end
    if (cmd.offs) begin
      for (int i = 0; i < 3; i++) begin
        ofs_r[2*i]   <= OFS_W'(vtx_r[2*i]) - gx8;
        ofs_r[2*i+1] <= OFS_W'(vtx_r[2*i+1]) - gy8;
      end
    end
    // ofs order: ux uy vx vy wx wy
    if (cmd.prod) begin
      prd_r[0] <= ofs_r[2] * ofs_r[5];
      prd_r[1] <= ofs_r[3] * ofs_r[4];
      prd_r[2] <= ofs_r[4] * ofs_r[1];
      prd_r[3] <= ofs_r[5] * ofs_r[0];
      prd_r[4] <= ofs_r[0] * ofs_r[3];
      prd_r[5] <= ofs_r[1] * ofs_r[2];
    end
    if (cmd.coef) begin
      ca_r[0] <= ofs_r[3] - ofs_r[5];
      cb_r[0] <= ofs_r[4] - ofs_r[2];
      cc_r[0] <= prd_r[0] - prd_r[1];
      ca_r[1] <= ofs_r[5] - ofs_r[1];
      cb_r[1] <= ofs_r[0] - ofs_r[4];
      cc_r[1] <= prd_r[2] - prd_r[3];
      ca_r[2] <= ofs_r[1] - ofs_r[3];
      cb_r[2] <= ofs_r[2] - ofs_r[0];
      cc_r[2] <= prd_r[4] - prd_r[5];
    end
    // make the orientation positive
    if (cmd.flip && area[AREA_W-1]) begin
      for (int i = 0; i < 3; i++) begin
        ca_r[i] <= -ca_r[i];
        cb_r[i] <= -cb_r[i];
        cc_r[i] <= -cc_r[i];
      end
    end
    if (cmd.mult) begin
      for (int i = 0; i < 3; i++) begin
        bdy_r[i] <= cb_r[i] * dy;
      end
    end
    if (cmd.merge) begin
      start_r <= st_c;
      end_r   <= en_c;
    end
  end

  // tightest span bounds over edges with nonzero A
  always_comb begin
    st_c = RES_W'(box_lo_r);
    en_c = RES_W'(box_hi_r);
    cand = '0;
    for (int i = 0; i < 3; i++) begin
      if (ca_r[i] != '0) begin
        if (!ca_r[i][OFS_W-1]) begin
          cand = RES_W'(gx_r) - RES_W'(div_quo[i]);
          if (cand > st_c) begin
            st_c = cand;
          end
        end else begin
          cand = RES_W'(div_quo[i]) + RES_W'(gx_r);
          if (cand < en_c) begin
            en_c = cand;
          end
        end
      end
    end
  end

  // clamp to the output range
  always_comb begin
    in_rng = (start_r >= OUT_MIN) && (start_r <= OUT_MAX) &&
             (end_r >= OUT_MIN) && (end_r <= OUT_MAX);
    if (in_rng) begin
      so = start_r;
      eo = end_r;
    end else if (start_r <= end_r) begin
      so = clip(start_r, OUT_MIN, OUT_MAX);
      eo = clip(end_r, OUT_MIN, OUT_MAX);
    end else begin
      eo = clip(end_r, OUT_MIN, OUT_MAX - RES_W'(1));
      so = eo + RES_W'(1);
    end
    row_c = clip(RES_W'(cur_r), OUT_MIN, OUT_MAX);
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_user_r <= cmd.out_status;
      if (cmd.out_status == ST_SPAN) begin
        out_data_r <= {OUT_W'(eo), OUT_W'(so), OUT_W'(row_c)};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign sts.out_full = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser    = out_user_r;

endmodule

[sv/tess_ctrl.sv]
module tess_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_kind,
  output logic            in_tready,
  input  tess_pkg::sts_t  sts,
  output tess_pkg::cmd_t  cmd
);
  import tess_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'h0001,
    S_LOAD  = 13'h0002,
    S_CDIV  = 13'h0004,
    S_OFFS  = 13'h0008,
    S_PROD  = 13'h0010,
    S_COEF  = 13'h0020,
    S_FLIP  = 13'h0040,
    S_STEP  = 13'h0080,
    S_MULT  = 13'h0100,
    S_NUMR  = 13'h0200,
    S_SDIV  = 13'h0400,
    S_MERGE = 13'h0800,
    S_RESP  = 13'h1000
  } state_t;

  state_t  state_r, state_nxt;
  status_t res_r, res_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (!in_kind) begin
            cmd.capture = 1'b1;
            state_nxt   = S_LOAD;
          end else begin
            state_nxt = S_STEP;
          end
        end
      end
      S_LOAD: begin
        cmd.load_box  = 1'b1;
        state_nxt     = S_CDIV;
      end
      S_CDIV: begin
        cmd.cent_take = 1'b1;
        state_nxt     = S_OFFS;
      end
      S_OFFS: begin
        cmd.offs  = 1'b1;
        state_nxt = S_PROD;
      end
      S_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = S_COEF;
      end
      S_COEF: begin
        cmd.coef  = 1'b1;
        state_nxt = S_FLIP;
      end
      S_FLIP: begin
        cmd.flip  = 1'b1;
        res_nxt   = ST_LOADED;
        state_nxt = S_RESP;
      end
      S_STEP: begin
        if (sts.past_last) begin
          res_nxt   = ST_DONE;
          state_nxt = S_RESP;
        end else begin
          cmd.row_step = 1'b1;
          if (sts.next_past) begin
            res_nxt   = ST_DONE;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_MULT;
          end
        end
      end
      S_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = S_NUMR;
      end
      S_NUMR: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_SDIV;
      end
      S_SDIV: begin
        if (sts.div_done) begin
          state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        res_nxt   = ST_SPAN;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!sts.out_full) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = res_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= ST_DONE;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule

[sv/triangle_edge_span_scan.sv]
// Triangle span scanner. A load transaction (tuser 0) takes three vertices in signed
// fixed point with 8 fraction bits and sets up the bounding box, the floored centroid
// and three positively oriented edge lines; it answers status 0. Each advance
// transaction (tuser 1) moves one row down and answers the row and the inclusive span
// [start, end], status 1, or status 2 once the rows are used up (also the state right
// after reset). The span time is set by three radix-2 division lanes, one per edge,
// that each take 48 shift steps per quotient and then raise done; the centroid divides
// by three with a reciprocal multiply. After each answer the sequencer returns to idle,
// where the next transaction is taken. One transaction is in work at a time, and a new
// one is taken while the previous result still waits in the output register.
module triangle_edge_span_scan (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y
  input  logic [tess_pkg::IN_DATA_W-1:0]      in_tdata,
  // kind
  input  logic [0:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // row_y, span_start, span_end
  output logic [tess_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status
  output logic [1:0]                          out_tuser
);
  import tess_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  tess_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser[0]),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and output register
  tess_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[sv/tess_chk.sv]
module tess_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [tess_pkg::IN_DATA_W-1:0]      in_tdata,
  input logic [0:0]                          in_tuser,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [tess_pkg::OUT_DATA_W-1:0]     out_tdata,
  input logic [1:0]                          out_tuser
);
  import tess_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one transaction in work at a time
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // load and done results carry zero data
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_LOADED || out_tuser == ST_DONE) |-> out_tdata == '0)
    else $error("nonzero data on load or done result");

  // a result never appears the cycle right after a transaction is taken
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result too early");

endmodule

bind triangle_edge_span_scan tess_chk u_chk (.*);

[test/tb_triangle_edge_span_scan.sv]
`timescale 1ns / 100ps

module tb_triangle_edge_span_scan;
  import tess_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;

  // one scanline command as sent to the block
  typedef struct {
    logic kind;
    logic signed [23:0] v[6];
  } scan_cmd_t;

  typedef struct {
    status_t status;
    logic signed [15:0] row_y;
    logic signed [15:0] span_start;
    logic signed [15:0] span_end;
  } span_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;

  triangle_edge_span_scan DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  scan_cmd_t pending_cmds[$];
  span_result_t expected_spans[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  int loads_sent = 0;
  int spans_seen = 0;
  int dones_seen = 0;
  int in_accepts = 0;
  int in_pops = 0;
  bit watchdog_fired = 0;

  // scanner state mirror
  longint box_lo, box_hi, row_last, row_cur, cen_x, cen_y;
  longint coef_a[3], coef_b[3], coef_c[3];

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) q--;
    return q;
  endfunction

  function automatic longint ceil_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) == (d < 0))) q++;
    return q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic scanner_reset();
    box_lo = 0; box_hi = 0; row_last = -1; row_cur = 0; cen_x = 0; cen_y = 0;
    for (int i = 0; i < 3; i++) begin
      coef_a[i] = 0; coef_b[i] = 0; coef_c[i] = 0;
    end
  endtask

  // advance the mirror by one command and return the span it should produce
  function automatic span_result_t predict_span(scan_cmd_t c);
    span_result_t r;
    longint one, p[6], ux, uy, vx, vy, wx, wy, area, st, en, dy, num, den, lo, hi;
    one = longint'(1) << COORD_FRAC_BITS;
    lo = -(longint'(1) << (COORD_INT_BITS - 1));
    hi = (longint'(1) << (COORD_INT_BITS - 1)) - 1;
    r.status = ST_LOADED; r.row_y = 0; r.span_start = 0; r.span_end = 0;
    if (!c.kind) begin
      for (int i = 0; i < 6; i++) p[i] = longint'(c.v[i]);
      box_lo = ceil_div((p[0] < p[2]) ? ((p[0] < p[4]) ? p[0] : p[4])
                                      : ((p[2] < p[4]) ? p[2] : p[4]), one);
      box_hi = floor_div((p[0] > p[2]) ? ((p[0] > p[4]) ? p[0] : p[4])
                                       : ((p[2] > p[4]) ? p[2] : p[4]), one);
      row_cur = ceil_div((p[1] < p[3]) ? ((p[1] < p[5]) ? p[1] : p[5])
                                       : ((p[3] < p[5]) ? p[3] : p[5]), one) - 1;
      row_last = floor_div((p[1] > p[3]) ? ((p[1] > p[5]) ? p[1] : p[5])
                                         : ((p[3] > p[5]) ? p[3] : p[5]), one);
      cen_x = floor_div(p[0] + p[2] + p[4], 3 * one);
      cen_y = floor_div(p[1] + p[3] + p[5], 3 * one);
      ux = p[0] - cen_x * one; uy = p[1] - cen_y * one;
      vx = p[2] - cen_x * one; vy = p[3] - cen_y * one;
      wx = p[4] - cen_x * one; wy = p[5] - cen_y * one;
      coef_a[0] = vy - wy; coef_b[0] = wx - vx; coef_c[0] = vx * wy - vy * wx;
      coef_a[1] = wy - uy; coef_b[1] = ux - wx; coef_c[1] = wx * uy - wy * ux;
      coef_a[2] = uy - vy; coef_b[2] = vx - ux; coef_c[2] = ux * vy - uy * vx;
      area = vx * wy - vx * uy - ux * wy - wx * vy + wx * uy + ux * vy;
      if (area < 0) begin
        for (int i = 0; i < 3; i++) begin
          coef_a[i] = -coef_a[i]; coef_b[i] = -coef_b[i]; coef_c[i] = -coef_c[i];
        end
      end
      return r;
    end
    // done once past the bottom row; the row counter stops there
    if (row_cur > row_last) begin
      r.status = ST_DONE;
      return r;
    end
    row_cur++;
    if (row_cur > row_last) begin
      r.status = ST_DONE;
      return r;
    end
    st = box_lo; en = box_hi;
    dy = row_cur - cen_y;
    for (int i = 0; i < 3; i++) begin
      if (coef_a[i] == 0) continue;
      num = -(coef_b[i] * dy * one + coef_c[i]);
      den = coef_a[i] * one;
      if (coef_a[i] > 0) begin
        if (ceil_div(num, den) + cen_x > st) st = ceil_div(num, den) + cen_x;
      end else begin
        if (floor_div(num, den) + cen_x < en) en = floor_div(num, den) + cen_x;
      end
    end
    // out of range spans: clamp, keeping empty spans empty
    if (st < lo || st > hi || en < lo || en > hi) begin
      if (st <= en) begin
        st = clip(st, lo, hi); en = clip(en, lo, hi);
      end else begin
        en = clip(en, lo, hi - 1); st = en + 1;
      end
    end
    r.status = ST_SPAN;
    r.row_y = 16'(clip(row_cur, lo, hi));
    r.span_start = 16'(st);
    r.span_end = 16'(en);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  function automatic scan_cmd_t make_load(longint ax, longint ay, longint bx, longint by,
                                          longint cx, longint cy);
    scan_cmd_t c;
    c.kind = 1'b0;
    c.v[0] = 24'(ax); c.v[1] = 24'(ay); c.v[2] = 24'(bx);
    c.v[3] = 24'(by); c.v[4] = 24'(cx); c.v[5] = 24'(cy);
    return c;
  endfunction

  function automatic scan_cmd_t make_advance();
    scan_cmd_t c;
    c.kind = 1'b1;
    for (int i = 0; i < 6; i++) c.v[i] = 24'($urandom);
    return c;
  endfunction

  // small triangle near a random point, sometimes anywhere in range
  function automatic scan_cmd_t random_triangle();
    longint base_x, base_y, span;
    scan_cmd_t c;
    if ($urandom_range(0, 9) == 0) begin
      c.kind = 1'b0;
      for (int i = 0; i < 6; i++) c.v[i] = 24'($urandom);
      return c;
    end
    base_x = longint'($signed(24'($urandom)));
    base_y = longint'($signed(24'($urandom)));
    if ($urandom_range(0, 3) == 0) begin
      base_x = longint'($urandom_range(0, 8000)) - 4000;
      base_y = longint'($urandom_range(0, 8000)) - 4000;
    end
    span = longint'($urandom_range(1, 3)) == 1 ? 600 : 3000;
    c.kind = 1'b0;
    for (int i = 0; i < 6; i++) begin
      longint b;
      b = (i % 2) ? base_y : base_x;
      c.v[i] = 24'(clip(b + longint'($urandom_range(0, span)), -8388608, 8388607));
    end
    return c;
  endfunction

  // driver: present items from the pending queue, drop the head once it is taken
  always @(negedge clk) begin
    bit took;
    took = 1'b0;
    if (rst_n) begin
      if (in_pops != in_accepts) begin
        in_pops++;
        took = 1'b1;
        if (pending_cmds.size() > 0) void'(pending_cmds.pop_front());
      end
      if ((!in_tvalid || took) && pending_cmds.size() > 0 &&
          ($urandom_range(1, 100) > send_idle_pct)) begin
        in_tvalid <= 1'b1;
        in_tuser <= pending_cmds[0].kind;
        in_tdata <= {pending_cmds[0].v[5], pending_cmds[0].v[4], pending_cmds[0].v[3],
                     pending_cmds[0].v[2], pending_cmds[0].v[1], pending_cmds[0].v[0]};
      end else if (!in_tvalid || took) begin
        in_tvalid <= 1'b0;
      end
      out_tready <= ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  // the queue head stays until the item is taken; prediction happens on acceptance
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      scan_cmd_t c;
      c.kind = in_tuser[0];
      for (int i = 0; i < 6; i++) c.v[i] = in_tdata[i*24 +: 24];
      if (!c.kind) loads_sent++;
      in_accepts++;
      expected_spans.push_back(predict_span(c));
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_spans.size() == 0) begin
        $display("mismatch: unexpected result at %0t", $time);
        mismatch_count++;
      end else begin
        span_result_t w;
        w = expected_spans.pop_front();
        if (out_tuser !== w.status) report_mismatch("status", out_tuser, w.status);
        if (out_tdata[15:0] !== w.row_y) report_mismatch("row_y",
            $signed(out_tdata[15:0]), w.row_y);
        if (out_tdata[31:16] !== w.span_start) report_mismatch("span_start",
            $signed(out_tdata[31:16]), w.span_start);
        if (out_tdata[47:32] !== w.span_end) report_mismatch("span_end",
            $signed(out_tdata[47:32]), w.span_end);
        if (w.status == ST_SPAN) spans_seen++;
        if (w.status == ST_DONE) dones_seen++;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else if (pending_cmds.size() > 0 || expected_spans.size() > 0)
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !watchdog_fired) begin
        watchdog_fired = 1;
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || expected_spans.size() > 0) @(posedge clk);
  endtask

  initial begin
    int rows;
    scanner_reset();
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: done after reset, every shape case, extremes
    pending_cmds.push_back(make_advance());
    pending_cmds.push_back(make_load(0, 0, 1024, 0, 0, 1024));
    repeat (6) pending_cmds.push_back(make_advance());
    pending_cmds.push_back(make_load(0, 0, 0, 1024, 1024, 0));
    repeat (3) pending_cmds.push_back(make_advance());
    pending_cmds.push_back(make_load(0, 0, 512, 512, 1024, 1024));
    repeat (2) pending_cmds.push_back(make_advance());
    pending_cmds.push_back(make_load(100, 100, 200, 120, 150, 200));
    repeat (2) pending_cmds.push_back(make_advance());
    pending_cmds.push_back(make_load(-8388608, -8388608, 8388607, -8388608,
                                     -8388608, 8388607));
    repeat (3) pending_cmds.push_back(make_advance());
    pending_cmds.push_back(make_load(8388607, 8388607, -8388608, 8388607,
                                     8388607, -8388608));
    pending_cmds.push_back(make_advance());
    wait_drained();

    // random phases with different idling mixes
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? 69 : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? 69 : 0;
      if (phase == 3) begin
        send_idle_pct = 6; recv_stall_pct = 6;
      end
      for (int n = 0; n < 200; ) begin
        pending_cmds.push_back(random_triangle());
        n++;
        rows = $urandom_range(0, 14);
        for (int k = 0; k < rows && n < 200; k++) begin
          pending_cmds.push_back($urandom_range(0, 19) == 0 ? random_triangle()
                                                            : make_advance());
          n++;
        end
        while (pending_cmds.size() > 8) @(posedge clk);
      end
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d triangle loads, %0d spans and %0d done answers",
             loads_sent, spans_seen, dones_seen);
    $display("across four handshake idling mixes");
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[triangle_edge_span_scan.f]
sv/tess_pkg.sv
sv/tess_div.sv
sv/tess_dp.sv
sv/tess_ctrl.sv
sv/triangle_edge_span_scan.sv
sv/tess_chk.sv
test/tb_triangle_edge_span_scan.sv
